### hdl/hann_window_apply_defines.svh
// Assertion macros shared by the Hann window RTL.
// Expects signals clk and rst_n in the scope where the macros are used.
// Defining SYNTH turns every macro into an empty body.
`ifndef HANN_WINDOW_APPLY_DEFINES_SVH
`define HANN_WINDOW_APPLY_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside of reset.
`define HWA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define HWA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HWA_ASSERT_IMP(label, ante, cons, msg)
`define HWA_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### hdl/hwa_pkg.sv
// Package for the Hann window block: field widths, defaults and the table function.
// No dependencies; used by hwa_coef_rom and hann_window_apply.
`timescale 1ns / 1ps

package hwa_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int CFG_W          = 13;
    localparam int PHASE_W        = 17;
    localparam int CLAMP_W        = 17;
    localparam int PHASE_ONE      = 65536;
    localparam int RESET_LEN      = 1024;
    localparam int MIN_LEN        = 2;
    localparam int DEF_MAX_LEN    = 4096;
    localparam int DEF_TABLE_BITS = 12;
    localparam int OUT_DATA_W     = SAMPLE_W + COEF_W;

    localparam real TWO_PI = 6.283185307179586;

    // Entry k of a Hann table with 2**bits entries, rounded half up.
    // The upper half mirrors the lower half; the exact points are fixed.
    function automatic logic [COEF_W-1:0] hann_entry(input int k, input int bits);
        int  size;
        int  half;
        int  quarter;
        int  r;
        int  b;
        real scale;
        real ang;
        real v;
        size    = 1 << bits;
        half    = size >> 1;
        quarter = size >> 2;
        scale   = 1.0;
        for (b = 0; b < bits; b++)
        begin
            scale = scale * 0.5;
        end
        r = k;
        if (r > half)
        begin
            r = size - r;
        end
        if (r == 0)
        begin
            return '0;
        end
        if (r == half)
        begin
            return 16'hFFFF;
        end
        if (r == quarter)
        begin
            return 16'h8000;
        end
        ang = TWO_PI * real'(r) * scale;
        v   = 65535.0 * 0.5 * (1.0 - $cos(ang));
        return COEF_W'($rtoi($floor(v + 0.5)));
    endfunction

endpackage

### hdl/hwa_coef_rom.sv
// Constant Hann coefficient table with a registered read port.
// Depends on hwa_pkg for the entry function and coefficient width.
`timescale 1ns / 1ps

module hwa_coef_rom #(
    parameter int TABLE_BITS = hwa_pkg::DEF_TABLE_BITS
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [TABLE_BITS-1:0]      rd_addr,
    output logic [hwa_pkg::COEF_W-1:0] rd_data
);
    import hwa_pkg::*;

    localparam int TABLE_SIZE = 1 << TABLE_BITS;

    logic [COEF_W-1:0] rom_tab [TABLE_SIZE];
    logic [COEF_W-1:0] rd_data_reg;

    for (genvar k = 0; k < TABLE_SIZE; k++)
    begin : g_tab
        assign rom_tab[k] = hann_entry(k, TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom_tab[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/hann_window_apply.sv
// Hann window on a sample stream. A result beat passes the registered table read, then
// the multiply into the output register.
// Throughput: one beat per cycle outside a step divide, limited by the output handshake.
// A length write stalls s_tready while a one-bit-per-cycle divider forms the phase step.
// Reset (rst_n low, asynchronous) selects length 1024 and frame start.
// Depends on hwa_pkg, hwa_coef_rom and hann_window_apply_defines.svh.
`timescale 1ns / 1ps
`include "hann_window_apply_defines.svh"

module hann_window_apply #(
    parameter int MAX_LEN    = hwa_pkg::DEF_MAX_LEN,
    parameter int TABLE_BITS = hwa_pkg::DEF_TABLE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hwa_pkg::CFG_W-1:0]      cfg_wdata,   // window_len
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hwa_pkg::SAMPLE_W-1:0]   s_tdata,     // [15:0] sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hwa_pkg::OUT_DATA_W-1:0] m_tdata,     // [15:0] windowed, [31:16] coefficient
    output logic                           m_tlast      // last_of_frame
);
    import hwa_pkg::*;

    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int RST_LEN     = (RESET_LEN < MAX_LEN) ? RESET_LEN : MAX_LEN;
    localparam int RST_STEP_W  = PHASE_ONE / (RST_LEN - 1);
    localparam int RST_STEP_R  = PHASE_ONE % (RST_LEN - 1);
    localparam int CNT_W       = $clog2(PHASE_W + 1);

    // Frame position and phase state.
    logic [IDX_W-1:0]   len_m1_reg,     len_m1_next;
    logic [IDX_W-1:0]   index_reg,      index_next;
    logic [PHASE_W-1:0] phase_acc_reg,  phase_acc_next;
    logic [IDX_W-1:0]   phase_rem_reg,  phase_rem_next;
    logic [PHASE_W-1:0] step_whole_reg, step_whole_next;
    logic [IDX_W-1:0]   step_rem_reg,   step_rem_next;

    // Step divider.
    logic               busy_reg,       busy_next;
    logic [CNT_W-1:0]   div_cnt_reg,    div_cnt_next;
    logic [PHASE_W-1:0] div_quot_reg,   div_quot_next;
    logic [IDX_W-1:0]   div_rem_reg,    div_rem_next;

    // Pipeline.
    logic                s1_valid_reg,  s1_valid_next;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_last_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_wind_reg;
    logic [COEF_W-1:0]   out_coef_reg;
    logic                out_last_reg;

    logic                in_acc;
    logic                adv_out;
    logic                is_last;
    logic [COEF_W-1:0]   rom_coef;
    logic [CLAMP_W-1:0]  len_raw;
    logic [CLAMP_W-1:0]  len_clamped;
    logic [IDX_W:0]      rem_sum;
    logic [IDX_W:0]      div_shift;
    logic                div_ge;
    logic signed [SAMPLE_W+COEF_W:0] product;

    assign adv_out  = !out_valid_reg || m_tready;
    assign s_tready = !busy_reg && (!s1_valid_reg || adv_out);
    assign in_acc   = s_tvalid && s_tready;
    assign is_last  = (index_reg == len_m1_reg);

    hwa_coef_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_coef_rom (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (phase_acc_reg[PHASE_W-2 -: TABLE_BITS]),
        .rd_data (rom_coef)
    );

    always_comb
    begin
        len_raw     = {{(CLAMP_W-CFG_W){1'b0}}, cfg_wdata};
        len_clamped = len_raw;
        if (len_raw < CLAMP_W'(MIN_LEN))
        begin
            len_clamped = CLAMP_W'(MIN_LEN);
        end
        else if (len_raw > CLAMP_W'(MAX_LEN))
        begin
            len_clamped = CLAMP_W'(MAX_LEN);
        end
    end

    // Restoring division of 65536 by N-1, one quotient bit per cycle.
    always_comb
    begin
        div_shift = {div_rem_reg, (div_cnt_reg == CNT_W'(PHASE_W))};
        div_ge    = (div_shift >= {1'b0, len_m1_reg});
        if (div_ge)
        begin
            div_rem_next = IDX_W'(div_shift - {1'b0, len_m1_reg});
        end
        else
        begin
            div_rem_next = div_shift[IDX_W-1:0];
        end
        div_quot_next = {div_quot_reg[PHASE_W-2:0], div_ge};
        div_cnt_next  = div_cnt_reg - CNT_W'(1);
    end

    always_comb
    begin
        len_m1_next     = len_m1_reg;
        index_next      = index_reg;
        phase_acc_next  = phase_acc_reg;
        phase_rem_next  = phase_rem_reg;
        step_whole_next = step_whole_reg;
        step_rem_next   = step_rem_reg;
        busy_next       = busy_reg;
        rem_sum         = {1'b0, phase_rem_reg} + {1'b0, step_rem_reg};

        if (cfg_we)
        begin
            len_m1_next    = IDX_W'(len_clamped - CLAMP_W'(1));
            index_next     = '0;
            phase_acc_next = '0;
            phase_rem_next = '0;
            busy_next      = 1'b1;
        end
        else if (busy_reg)
        begin
            if (div_cnt_reg == CNT_W'(1))
            begin
                busy_next       = 1'b0;
                step_whole_next = div_quot_next;
                step_rem_next   = div_rem_next;
            end
        end
        else if (in_acc)
        begin
            if (is_last)
            begin
                index_next     = '0;
                phase_acc_next = '0;
                phase_rem_next = '0;
            end
            else
            begin
                index_next = index_reg + IDX_W'(1);
                if (rem_sum >= {1'b0, len_m1_reg})
                begin
                    phase_rem_next = IDX_W'(rem_sum - {1'b0, len_m1_reg});
                    phase_acc_next = phase_acc_reg + step_whole_reg + PHASE_W'(1);
                end
                else
                begin
                    phase_rem_next = rem_sum[IDX_W-1:0];
                    phase_acc_next = phase_acc_reg + step_whole_reg;
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv_out)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = adv_out ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_m1_reg     <= IDX_W'(RST_LEN - 1);
            index_reg      <= '0;
            phase_acc_reg  <= '0;
            phase_rem_reg  <= '0;
            step_whole_reg <= PHASE_W'(RST_STEP_W);
            step_rem_reg   <= IDX_W'(RST_STEP_R);
            busy_reg       <= 1'b0;
            div_cnt_reg    <= '0;
            div_quot_reg   <= '0;
            div_rem_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            len_m1_reg     <= len_m1_next;
            index_reg      <= index_next;
            phase_acc_reg  <= phase_acc_next;
            phase_rem_reg  <= phase_rem_next;
            step_whole_reg <= step_whole_next;
            step_rem_reg   <= step_rem_next;
            busy_reg       <= busy_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                div_cnt_reg  <= CNT_W'(PHASE_W);
                div_quot_reg <= '0;
                div_rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                div_cnt_reg  <= div_cnt_next;
                div_quot_reg <= div_quot_next;
                div_rem_reg  <= div_rem_next;
            end
        end
    end

    // Sign-extended sample times zero-extended coefficient; bits 31:16 are the floor.
    assign product = $signed(s1_sample_reg) * $signed({1'b0, rom_coef});

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sample_reg <= s_tdata;
            s1_last_reg   <= is_last;
        end
        if (adv_out && s1_valid_reg)
        begin
            out_wind_reg <= product[SAMPLE_W+COEF_W-1 -: SAMPLE_W];
            out_coef_reg <= rom_coef;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_coef_reg, out_wind_reg};
    assign m_tlast  = out_last_reg;

    `HWA_ASSERT_IMP(a_busy_blocks_input, busy_reg, !s_tready, "input taken during step divide")
    `HWA_ASSERT_NXT(a_frame_wrap, in_acc && is_last && !cfg_we,
        (index_reg == '0) && (phase_acc_reg == '0), "frame did not restart after last beat")
    `HWA_ASSERT_IMP(a_rem_bound, 1'b1, phase_rem_reg < len_m1_reg, "phase remainder out of range")
    `HWA_ASSERT_IMP(a_index_bound, 1'b1, index_reg <= len_m1_reg, "position beyond frame end")
    `HWA_ASSERT_NXT(a_stage_hold, s1_valid_reg && !adv_out, s1_valid_reg,
        "pending beat dropped while output stalled")

endmodule

### sim/hann_window_checker.sv
// Checker for hann_window_apply: watches the length writes and both streams,
// predicts each result beat and compares it field by field.
// Depends on hwa_pkg for widths, the reset length and the length limits.
`timescale 1ns / 1ps

module hann_window_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hwa_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [hwa_pkg::SAMPLE_W-1:0]   s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [hwa_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             pending,
    output int                             errors,
    output int                             checked,
    output int                             frame_ends
);

    localparam int  LUT_BITS = hwa_pkg::DEF_TABLE_BITS;
    localparam int  LUT_SIZE = 1 << LUT_BITS;
    localparam real PI       = 3.141592653589793;

    typedef struct packed {
        logic [15:0] windowed;
        logic [15:0] coef;
        logic        last;
    } window_result_t;

    logic [15:0]    hann_lut [0:LUT_SIZE-1];
    window_result_t expected_results[$];
    window_result_t want;

    // Frame position and the phase floor(pos * 65536 / (len - 1)) as whole and fraction.
    logic [12:0]    frame_len;
    logic [11:0]    frame_pos;
    logic [16:0]    phase_whole;
    logic [12:0]    phase_frac;
    logic [16:0]    step_whole;
    logic [11:0]    step_frac;

    int             fail_count;
    int             result_count;
    int             last_count;

    function automatic logic [15:0] hann_weight(input int k);
        int  r;
        real v;
        r = (k > LUT_SIZE / 2) ? LUT_SIZE - k : k;
        if (r == 0)
        begin
            return 16'h0000;
        end
        if (r == LUT_SIZE / 2)
        begin
            return 16'hFFFF;
        end
        // At the quarter points the exact value is 32767.5, which rounds up.
        if (r == LUT_SIZE / 4)
        begin
            return 16'h8000;
        end
        v = 32767.5 * (1.0 - $cos(2.0 * PI * real'(r) / real'(LUT_SIZE)));
        return 16'($rtoi($floor(v + 0.5)));
    endfunction

    task automatic load_length(input logic [12:0] len);
        int n;
        n = len;
        if (n < hwa_pkg::MIN_LEN)
        begin
            n = hwa_pkg::MIN_LEN;
        end
        if (n > hwa_pkg::DEF_MAX_LEN)
        begin
            n = hwa_pkg::DEF_MAX_LEN;
        end
        frame_len   = 13'(n);
        step_whole  = 17'(hwa_pkg::PHASE_ONE / (n - 1));
        step_frac   = 12'(hwa_pkg::PHASE_ONE % (n - 1));
        frame_pos   = '0;
        phase_whole = '0;
        phase_frac  = '0;
    endtask

    task automatic window_sample(input logic [15:0] sample);
        logic signed [32:0] product;
        window_result_t     r;
        // The phase 65536 at the end of a frame wraps to table entry 0.
        r.coef     = hann_lut[phase_whole[15:16-LUT_BITS]];
        product    = $signed(sample) * $signed({1'b0, r.coef});
        r.windowed = product[31:16];
        r.last     = (frame_pos == frame_len - 13'd1);
        expected_results.push_back(r);
        if (r.last)
        begin
            frame_pos   = '0;
            phase_whole = '0;
            phase_frac  = '0;
        end
        else
        begin
            frame_pos   = frame_pos + 12'd1;
            phase_whole = phase_whole + step_whole;
            phase_frac  = phase_frac + 13'(step_frac);
            if (phase_frac >= frame_len - 13'd1)
            begin
                phase_frac  = phase_frac - (frame_len - 13'd1);
                phase_whole = phase_whole + 17'd1;
            end
        end
    endtask

    initial
    begin
        for (int k = 0; k < LUT_SIZE; k++)
        begin
            hann_lut[k] = hann_weight(k);
        end
        load_length(13'(hwa_pkg::RESET_LEN));
        fail_count   = 0;
        result_count = 0;
        last_count   = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_length(13'(hwa_pkg::RESET_LEN));
            expected_results.delete();
            pending <= 0;
            errors  <= fail_count;
        end
        else
        begin
            if (cfg_we)
            begin
                load_length(cfg_wdata);
            end
            if (s_tvalid && s_tready)
            begin
                window_sample(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no sample waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    result_count++;
                    if (want.last)
                    begin
                        last_count++;
                    end
                    if (m_tdata[15:0] !== want.windowed)
                    begin
                        $error("windowed: expected %0d, got %0d",
                               $signed(want.windowed), $signed(m_tdata[15:0]));
                        fail_count++;
                    end
                    if (m_tdata[31:16] !== want.coef)
                    begin
                        $error("coefficient: expected %0d, got %0d",
                               want.coef, m_tdata[31:16]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_frame: expected %0d, got %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            pending    <= expected_results.size();
            errors     <= fail_count;
            checked    <= result_count;
            frame_ends <= last_count;
        end
    end

endmodule

### sim/tb.sv
// Top of the Hann window testbench: clock, reset, sample stimulus, length writes
// and output back-pressure. Depends on hwa_pkg, hann_window_apply and hann_window_checker.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_SAMPLES = 1950;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [hwa_pkg::CFG_W-1:0]      cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [hwa_pkg::SAMPLE_W-1:0]   s_tdata;     // [15:0] sample
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [hwa_pkg::OUT_DATA_W-1:0] m_tdata;     // [15:0] windowed, [31:16] coefficient
    logic                           m_tlast;     // last_of_frame

    int   pending;
    int   errors;
    int   checked;
    int   frame_ends;

    // While steady is set neither side inserts idle cycles.
    logic steady = 1'b0;
    int   samples_sent = 0;
    int   length_writes = 0;

    hann_window_apply uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    hann_window_checker window_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .pending    (pending),
        .errors     (errors),
        .checked    (checked),
        .frame_ends (frame_ends)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 12);
    end

    // Holds tvalid across back-to-back beats; it only drops for an idle cycle.
    task automatic send_sample(input logic [15:0] value);
        while (!steady && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        samples_sent++;
    endtask

    // The length may only change once every result has drained.
    task automatic set_length(input logic [12:0] len);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
        length_writes++;
    endtask

    initial
    begin
        int          pick;
        int          len;
        int          frame_len;
        int          burst;
        logic [15:0] value;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset length of 1024, sample extremes.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h0000);

        // Zero clamps to the shortest frame; its second position wraps the phase.
        set_length(13'd0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);

        // Five positions hit the quarter points and the peak of the window.
        set_length(13'd5);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);

        // Clamping at both ends, then the longest frame.
        set_length(13'd1);
        set_length(13'd8191);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h1234);
        set_length(13'd4097);
        set_length(13'd4096);
        send_sample(16'h8000);
        send_sample(16'h7FFF);

        // A write in the middle of a frame restarts it.
        set_length(13'd3);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h5A5A);
        send_sample(16'hA5A5);

        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                len = $urandom_range(2, 40);
            end
            else if (pick < 90)
            begin
                len = $urandom_range(41, 700);
            end
            else if (pick < 95)
            begin
                len = $urandom_range(701, 4096);
            end
            else
            begin
                case ($urandom_range(4))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = 4096;
                    3:       len = 8191;
                    default: len = $urandom_range(4097, 8191);
                endcase
            end
            set_length(13'(len));
            frame_len = (len < 2) ? 2 : (len > 4096) ? 4096 : len;
            burst = frame_len * $urandom_range(1, 3) + $urandom_range(0, 2);
            if (burst > 300)
            begin
                burst = $urandom_range(50, 300);
            end
            for (int n = 0; n < burst && samples_sent < RANDOM_SAMPLES; n++)
            begin
                case ($urandom_range(19))
                    0:       value = 16'h8000;
                    1:       value = 16'h7FFF;
                    2:       value = 16'hFFFF;
                    3:       value = 16'h0000;
                    default: value = 16'($urandom);
                endcase
                steady <= (samples_sent >= 700 && samples_sent < 1100);
                send_sample(value);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Windowed %0d result beats across %0d frame ends with %0d length writes,",
                 checked, frame_ends, length_writes);
        $display("covering lengths from 2 to 4096, clamped writes and mid-frame restarts.");
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### hann_window_apply.f
+incdir+hdl
hdl/hwa_pkg.sv
hdl/hwa_coef_rom.sv
hdl/hann_window_apply.sv
sim/hann_window_checker.sv
sim/tb.sv
